// ===== rtl/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline basis evaluator package
// Shared types and constants for the knot store, divider and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package bsb_pkg;

  localparam int unsigned KnotW     = 32;
  localparam int unsigned BasW      = 31;
  localparam int unsigned MaxKnots  = 64;
  localparam int unsigned MaxDegree = 7;
  localparam logic [BasW-1:0] OneQ30 = 31'h4000_0000;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    REG_DEGREE     = 1'b0,
    REG_KNOT_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CLAMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INIT,
    ST_RAT_RD_LO,
    ST_RAT_RD_HI,
    ST_RAT_DIV,
    ST_RAT_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic       start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/bsb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bsb_div.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring divider giving floor(num * 2^30 / den), one quotient bit a cycle.
// Caller guarantees 0 < num < den.
// ----------------------------------------------------------------------------
`default_nettype none
module bsb_div
  import bsb_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire div_req_t       req,
  output logic                busy,
  output logic [BasW-1:0]     quot
);
  logic [32:0]     rem_r, rem_nxt;
  logic [31:0]     den_r;
  logic [BasW-1:0] q_r, q_nxt;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic [33:0]     trial;

  assign trial = {rem_r, 1'b0} - {2'b00, den_r};

  always_comb begin
    rem_nxt = {rem_r[31:0], 1'b0};
    q_nxt   = {q_r[BasW-2:0], 1'b0};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd29;
      rem_r  <= {1'b0, req.num};
      den_r  <= req.den;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== rtl/bspline_basis_evaluator.sv =====
// ----------------------------------------------------------------------------
// B-spline basis evaluator
// Cox-de Boor basis evaluation over a loadable knot vector.
// ----------------------------------------------------------------------------
// A load transaction writes one knot, and loads may follow back to back. An
// evaluate transaction keeps in_ready low until its last result is taken:
// RD_LO, RD_HI and CLAMP fetch the end knots and clamp u, the span search
// reads and compares each knot of t[p..n-1], INIT seeds the work array, then
// p*(p+3)/2 element updates follow, each through RAT_RD_LO, RAT_RD_HI,
// RAT_DIV, MUL_A, MUL_B and MUL_C, with a wait in RAT_WAIT whenever the
// one-bit-a-cycle divider has to run, and EMIT sends the results. A bad
// configuration goes through ERR to its single error result. Results leave
// through a one-deep output register that holds under back-pressure.
`default_nettype none
module bspline_basis_evaluator
  import bsb_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_func,
  input  wire logic [5:0]      in_index,
  input  wire logic [31:0]     in_value,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [30:0]          out_basis_value,
  output logic [5:0]           out_basis_number,
  output logic [5:0]           out_span,
  output logic                 out_config_error,
  output logic                 out_last,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [0:0]      cfg_index,
  input  wire logic [31:0]     cfg_data
);
  localparam int unsigned AW = $clog2(MaxKnots);
  localparam int unsigned NB = MaxDegree + 1;
  localparam int unsigned BW = $clog2(NB + 1);

  state_t state_r, state_nxt;
  logic [2:0]  degree_r;
  logic [6:0]  kcount_r;
  logic [31:0] u_r, tn_r, dlo_r;
  logic [6:0]  j_r, n_r, mu_r, k_r;
  logic [BW-1:0] r_r, i_r;
  logic [BasW-1:0] work_r [NB];
  logic [BasW-1:0] lam_r, acc_r;
  logic [60:0] prod_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rdata;
  logic [6:0] raddr_w;
  div_req_t dreq;
  logic dbusy;
  logic [BasW-1:0] dquot;
  logic [7:0] e_need;
  logic bad_cfg;
  logic [32:0] d_w, num_w;
  logic [BasW-1:0] mul_a, mul_b;
  logic [BasW:0] sum_w;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !out_valid;
  assign we    = in_valid && in_ready && (in_func == FUNC_LOAD)
              && ({1'b0, in_index} < 7'(MaxKnots));
  assign waddr = AW'(in_index);
  assign raddr = AW'(raddr_w);

  bsb_ram #(.Width(32), .Depth(MaxKnots)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_value), .raddr(raddr), .rdata(rdata)
  );

  bsb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dquot));

  assign e_need  = {4'b0, degree_r, 1'b0} + 8'd2;
  assign bad_cfg = ({29'b0, degree_r} > 32'(MaxDegree)) || ({25'b0, kcount_r} > 32'(MaxKnots))
                || ({1'b0, kcount_r} < e_need);

  // ratio operands: hi = rdata, lo = dlo_r
  assign d_w   = {1'b0, rdata} - {1'b0, dlo_r};
  assign num_w = {1'b0, rdata} - {1'b0, u_r};
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = num_w[31:0];
    dreq.den   = d_w[31:0];
    if (state_r == ST_RAT_DIV && !(d_w[32] || d_w == 33'd0 || num_w[32] || num_w == 33'd0
        || num_w >= d_w)) begin
      dreq.start = 1'b1;
    end
  end

  // read address selection
  always_comb begin
    raddr_w = j_r;
    case (state_r)
      ST_IDLE:      raddr_w = {4'b0, degree_r};
      ST_RD_LO:     raddr_w = n_r;
      ST_RAT_RD_LO: raddr_w = k_r;
      ST_RAT_RD_HI: raddr_w = k_r + {3'b0, r_r};
      ST_RAT_DIV:   raddr_w = k_r + {3'b0, r_r};
      default:      raddr_w = j_r;
    endcase
  end

  // the single unit: one Q1.30 multiplier, always fed with B[i+1]
  always_comb begin
    mul_a = lam_r;
    mul_b = (i_r == BW'(NB - 1)) ? '0 : work_r[i_r[BW-2:0] + (BW-1)'(1)];
    case (state_r)
      ST_MUL_B: mul_a = OneQ30 - lam_r;
      default:  mul_a = lam_r;
    endcase
  end
  assign sum_w = {1'b0, acc_r} + {1'b0, prod_r[60:30]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:
        if (in_valid && in_ready && in_func == FUNC_EVAL) begin
          state_nxt = bad_cfg ? ST_ERR : ST_RD_LO;
        end
      ST_RD_LO:    state_nxt = ST_RD_HI;
      ST_RD_HI:    state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = (j_r < n_r) ? ST_SRCH_RD : ST_INIT;
      ST_SRCH_RD:  state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = (j_r + 7'd1 < n_r) ? ST_SRCH_RD : ST_INIT;
      ST_INIT:     state_nxt = (degree_r == 3'd0) ? ST_EMIT : ST_RAT_RD_LO;
      ST_RAT_RD_LO: state_nxt = ST_RAT_RD_HI;
      ST_RAT_RD_HI: state_nxt = ST_RAT_DIV;
      ST_RAT_DIV:  state_nxt = dreq.start ? ST_RAT_WAIT : ST_MUL_A;
      ST_RAT_WAIT: if (!dbusy && !dreq.start) state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_MUL_C;
      ST_MUL_C: begin
        if (i_r == {1'b0, degree_r}) begin
          state_nxt = (r_r == {1'b0, degree_r}) ? ST_EMIT : ST_RAT_RD_LO;
        end else begin
          state_nxt = ST_RAT_RD_LO;
        end
      end
      ST_EMIT:
        if (!out_valid || out_ready) begin
          if (j_r == {4'b0, degree_r}) state_nxt = ST_IDLE;
        end
      ST_ERR: if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      degree_r <= 3'd3;
      kcount_r <= 7'd8;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEGREE:     degree_r <= cfg_data[2:0];
          REG_KNOT_COUNT: kcount_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((state_r == ST_EMIT || state_r == ST_ERR) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= 61'({30'b0, mul_a} * {30'b0, mul_b});
    case (state_r)
      ST_IDLE: begin
        u_r <= in_value;
        n_r <= kcount_r - {4'b0, degree_r} - 7'd1;
      end
      ST_RD_LO: begin
        if (u_r < rdata) u_r <= rdata;
      end
      ST_RD_HI: begin
        tn_r <= rdata;
        if (u_r > rdata) u_r <= rdata;
        j_r  <= {4'b0, degree_r};
        mu_r <= {4'b0, degree_r};
      end
      ST_CLAMP: ;
      ST_SRCH_CMP: begin
        if (rdata <= u_r && rdata < tn_r) mu_r <= j_r;
        j_r <= j_r + 7'd1;
      end
      ST_INIT: begin
        for (int q = 0; q < NB; q++) begin
          work_r[q] <= (q == int'(degree_r)) ? OneQ30 : '0;
        end
        acc_r <= '0;
        r_r <= BW'(1);
        i_r <= BW'(degree_r) - BW'(1);
        k_r <= mu_r;
        j_r <= '0;
      end
      ST_RAT_RD_HI: dlo_r <= rdata;
      ST_RAT_DIV: begin
        if (d_w[32] || d_w == 33'd0 || num_w[32] || num_w == 33'd0) lam_r <= '0;
        else if (num_w >= d_w) lam_r <= OneQ30;
      end
      ST_RAT_WAIT: if (!dbusy) lam_r <= dquot;
      ST_MUL_A: ;
      ST_MUL_B: begin
        // element i gets (1-lam_prev)*B[i], held in acc_r, plus lam*B[i+1]
        work_r[i_r[BW-2:0]] <= (sum_w > {1'b0, OneQ30}) ? OneQ30 : sum_w[BasW-1:0];
      end
      ST_MUL_C: begin
        // carry (1-lam)*B[i+1] over to the next element
        acc_r <= prod_r[60:30];
        if (i_r == {1'b0, degree_r}) begin
          r_r <= r_r + BW'(1);
          i_r <= BW'(degree_r) - r_r - BW'(1);
          k_r <= mu_r - {3'b0, r_r};
        end else begin
          i_r <= i_r + BW'(1);
          k_r <= k_r + 7'd1;
        end
      end
      ST_EMIT:
        if (!out_valid || out_ready) begin
          out_basis_value  <= work_r[j_r[BW-2:0]];
          out_basis_number <= 6'(mu_r - {4'b0, degree_r} + j_r);
          out_span         <= mu_r[5:0];
          out_config_error <= 1'b0;
          out_last         <= (j_r == {4'b0, degree_r});
          j_r <= j_r + 7'd1;
        end
      ST_ERR:
        if (!out_valid || out_ready) begin
          out_basis_value  <= '0;
          out_basis_number <= '0;
          out_span         <= '0;
          out_config_error <= 1'b1;
          out_last         <= 1'b1;
        end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/bsb_checker.sv =====
// ----------------------------------------------------------------------------
// B-spline basis evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bsb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_config_error,
  input wire logic        out_last,
  input wire logic [30:0] out_basis_value
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_basis_value))
    else $error("result dropped under stall");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_basis_value <= 31'h4000_0000)
    else $error("basis value above one");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_error |-> out_last && out_basis_value == 31'd0)
    else $error("bad error result");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepting while result pending");
endmodule

bind bspline_basis_evaluator bsb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_config_error(out_config_error), .out_last(out_last),
  .out_basis_value(out_basis_value)
);
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the B-spline basis evaluator
// Loads knot vectors and evaluates the basis at many parameters across
// several degree and knot-count settings. A scoreboard predicts every basis
// value and checks each result transaction. Both sides idle at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none
module tb
  import bsb_pkg::*;
();

  localparam int unsigned NumKnots = 64;
  localparam int unsigned TopDeg   = 7;
  localparam int unsigned DrainCyc = 1500;

  typedef struct packed {
    logic [30:0] basis_value;
    logic [5:0]  basis_number;
    logic [5:0]  span;
    logic        config_error;
    logic        last;
  } basis_res_t;

  typedef enum int {SHAPE_RAMP, SHAPE_FLAT, SHAPE_SHUFFLED} knot_shape_t;

  class basis_scoreboard;
    logic [31:0]  knots [NumKnots];
    int unsigned  deg = 3;
    int unsigned  kcount = 8;
    basis_res_t   pending_q [$];
    int unsigned  mismatches;
    int unsigned  n_results;
    int unsigned  n_errors_seen;

    function void set_reg(reg_idx_t idx, logic [31:0] data);
      if (idx == REG_DEGREE) deg = data[2:0];
      else kcount = data[6:0];
    endfunction

    function longint unsigned lambda_q30(logic [31:0] hi, logic [31:0] lo,
                                         logic [31:0] u);
      longint d, num;
      d   = longint'(hi) - longint'(lo);
      num = longint'(hi) - longint'(u);
      if (d <= 0 || num <= 0) return 0;
      if (num >= d) return 64'd1 << 30;
      return (longint'(num) << 30) / d;
    endfunction

    function longint unsigned mulq(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      return (a + b > (64'd1 << 30)) ? (64'd1 << 30) : a + b;
    endfunction

    function void note_input(func_t f, logic [5:0] idx, logic [31:0] val);
      longint unsigned work [TopDeg+1];
      longint unsigned lam;
      logic [31:0] u;
      int unsigned n, mu, k;
      basis_res_t res;
      if (f == FUNC_LOAD) begin
        knots[idx] = val;
        return;
      end
      if (deg > TopDeg || kcount > NumKnots || kcount < 2 * deg + 2) begin
        res = '0;
        res.config_error = 1'b1;
        res.last = 1'b1;
        pending_q.insert(pending_q.size(), res);
        return;
      end
      n = kcount - deg - 1;
      u = val;
      if (u < knots[deg]) u = knots[deg];
      if (u > knots[n]) u = knots[n];
      mu = deg;
      for (int unsigned j = deg; j < n; j++)
        if (knots[j] <= u && knots[j] < knots[n]) mu = j;
      foreach (work[i]) work[i] = 0;
      work[deg] = 64'd1 << 30;
      for (int r = 1; r <= int'(deg); r++) begin
        k = mu - r + 1;
        lam = lambda_q30(knots[k + r], knots[k], u);
        work[deg - r] = mulq(lam, work[deg - r + 1]);
        for (int i = deg - r + 1; i < int'(deg); i++) begin
          k++;
          work[i] = mulq((64'd1 << 30) - lam, work[i]);
          lam = lambda_q30(knots[k + r], knots[k], u);
          work[i] = sat_add(work[i], mulq(lam, work[i + 1]));
        end
        work[deg] = mulq((64'd1 << 30) - lam, work[deg]);
      end
      for (int unsigned j = 0; j <= deg; j++) begin
        res.basis_value  = work[j][30:0];
        res.basis_number = 6'(mu - deg + j);
        res.span         = 6'(mu);
        res.config_error = 1'b0;
        res.last         = (j == deg);
        pending_q.insert(pending_q.size(), res);
      end
    endfunction

    function void check_result(basis_res_t got);
      basis_res_t want;
      n_results++;
      if (got.config_error) n_errors_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.basis_value !== want.basis_value || got.basis_number !== want.basis_number
          || got.span !== want.span || got.config_error !== want.config_error
          || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected val %h num %0d span %0d err %b last %b",
                   want.basis_value, want.basis_number, want.span, want.config_error,
                   want.last);
          $display("          got      val %h num %0d span %0d err %b last %b",
                   got.basis_value, got.basis_number, got.span, got.config_error,
                   got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [5:0]  in_index = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] out_basis_value;
  logic [5:0]  out_basis_number;
  logic [5:0]  out_span;
  logic        out_config_error;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  basis_scoreboard sb = new();
  bit no_idle;
  int unsigned n_evals, n_loads;

  always #5 clk = ~clk;

  bspline_basis_evaluator dut (.*);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_basis_value, out_basis_number, out_span,
                       out_config_error, out_last});

  // result side: random hold-offs, one long one part way through
  initial begin
    int unsigned gap;
    bit held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && sb.n_results >= 120) begin
        held = 1'b1;
        @(negedge clk) out_ready = 1'b0;
        repeat (600) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        @(negedge clk) out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still expected", sb.pending_q.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(func_t f, logic [5:0] idx, logic [31:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func  = f;
    in_index = idx;
    in_value = val;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, idx, val);
    if (f == FUNC_EVAL) n_evals++;
    else n_loads++;
  endtask

  task automatic settle();
    @(negedge clk) in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    // every load has written its knot on acceptance; this wait only spaces the phases
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic load_knots(int unsigned cnt, knot_shape_t shape);
    logic [31:0] t;
    t = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32'h7fff_ffff) : $urandom_range(0, 255);
    for (int unsigned i = 0; i < cnt && i < NumKnots; i++) begin
      case (shape)
        SHAPE_RAMP: begin
          // repeat a knot now and then
          if ($urandom_range(0, 4) != 0) t += $urandom_range(1, 32'h0100_0000);
        end
        SHAPE_FLAT: ;
        default: t = $urandom;
      endcase
      send_item(FUNC_LOAD, 6'(i), t);
    end
  endtask

  function automatic logic [31:0] pick_u();
    int unsigned lo_i, hi_i;
    lo_i = sb.deg;
    hi_i = (sb.kcount > sb.deg + 1 && sb.kcount <= NumKnots) ? sb.kcount - sb.deg - 1 : lo_i;
    if (hi_i >= NumKnots) hi_i = NumKnots - 1;
    if (lo_i >= NumKnots) lo_i = NumKnots - 1;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return sb.knots[$urandom_range(0, NumKnots - 1)];
      3: return sb.knots[hi_i];
      default:
        if (sb.knots[hi_i] > sb.knots[lo_i])
          return $urandom_range(sb.knots[lo_i], sb.knots[hi_i]);
        else return sb.knots[lo_i];
    endcase
  endfunction

  task automatic run_phase(logic [31:0] d, logic [31:0] cnt, knot_shape_t shape,
                           int unsigned evals);
    settle();
    write_reg(REG_DEGREE, {$urandom} & ~32'h7 | d);
    write_reg(REG_KNOT_COUNT, {$urandom} & ~32'h7f | cnt);
    // a count beyond the table keeps the knots already there
    if (cnt <= NumKnots) load_knots(cnt, shape);
    for (int unsigned i = 0; i < evals; i++) begin
      // stray loads disturb the vector a little
      if ($urandom_range(0, 19) == 0)
        send_item(FUNC_LOAD, 6'($urandom_range(0, NumKnots - 1)), $urandom);
      else
        send_item(FUNC_EVAL, 6'($urandom), pick_u());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // fill the whole table so nothing unwritten is ever read
    load_knots(NumKnots, SHAPE_RAMP);
    send_item(FUNC_EVAL, 6'h3f, 32'h0);
    send_item(FUNC_EVAL, 6'h00, 32'hffff_ffff);
    send_item(FUNC_EVAL, 6'h15, sb.knots[3]);
    send_item(FUNC_EVAL, 6'h2a, sb.knots[4]);
    send_item(FUNC_LOAD, 6'h3f, 32'hffff_ffff);
    send_item(FUNC_EVAL, 6'h00, sb.knots[3] + 1);

    run_phase(1, 4, SHAPE_RAMP, 12);
    run_phase(7, 64, SHAPE_RAMP, 10);
    run_phase(7, 15, SHAPE_RAMP, 3);
    run_phase(0, 5, SHAPE_RAMP, 8);
    run_phase(2, 100, SHAPE_RAMP, 3);
    run_phase(2, 8, SHAPE_FLAT, 8);
    run_phase(3, 10, SHAPE_SHUFFLED, 14);
    no_idle = 1'b1;
    run_phase(2, 10, SHAPE_RAMP, 24);
    no_idle = 1'b0;
    run_phase(4, 20, SHAPE_RAMP, 24);
    run_phase(3, 8, SHAPE_RAMP, 24);
    run_phase(5, 12, SHAPE_RAMP, 12);
    run_phase(6, 127, SHAPE_RAMP, 3);

    settle();
    repeat (DrainCyc) @(posedge clk);
    $display("covered %0d evaluations and %0d knot loads, %0d results checked",
             n_evals, n_loads, sb.n_results);
    $display("degrees 0 to 7, knot counts 4 to 127, %0d configuration errors, %0d mismatches",
             sb.n_errors_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== bspline_basis_evaluator.f =====
rtl/bsb_pkg.sv
rtl/bsb_ram.sv
rtl/bsb_div.sv
rtl/bspline_basis_evaluator.sv
rtl/bsb_checker.sv
dv/tb.sv
